// ----- hdl/alu32_pkg.sv -----
// Package: operation codes, widths and the pipeline word shared by the ALU cells.
package alu32_pkg;

  localparam int DataWidth = 32;
  localparam int OpWidth   = 4;
  localparam int NumCells  = DataWidth;

  typedef enum logic [OpWidth-1:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_DIV  = 4'd3,
    OP_AND  = 4'd4,
    OP_OR   = 4'd5,
    OP_XOR  = 4'd6,
    OP_NOT  = 4'd7,
    OP_UADD = 4'd8,
    OP_USUB = 4'd9,
    OP_UMUL = 4'd10,
    OP_UDIV = 4'd11
  } alu_op_e;

  // Word carried from cell to cell. Each cell does one restoring-division
  // step and one shift-add multiply step.
  typedef struct packed {
    logic                 vld;
    logic [OpWidth-1:0]   op;
    logic [DataWidth-1:0] a;      // original A, for pass-through cases
    logic [DataWidth-1:0] b;      // original B
    logic [DataWidth-1:0] dvsr;   // |B| for divide, B for multiply
    logic [DataWidth-1:0] quo;    // dividend shifting out / quotient shifting in
    logic [DataWidth-1:0] rem;    // partial remainder
    logic [DataWidth-1:0] prod;   // partial product (low bits)
    logic [DataWidth-1:0] mcand;  // multiplicand, shifted left each cell
    logic                 qneg;
    logic                 rneg;
  } alu_word_t;

endpackage

// ----- hdl/alu32_cell.sv -----
// One cell of the ALU chain: one divide step and one multiply step.
module alu32_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  alu32_pkg::alu_word_t word_i,
  output alu32_pkg::alu_word_t word_o
);
  import alu32_pkg::*;

  alu_word_t            word_d, word_q;
  logic [DataWidth:0]   trial;
  logic [DataWidth-1:0] rsh;

  always_comb begin
    word_d = word_i;
    // restoring division: shift next dividend bit into the partial remainder
    rsh   = {word_i.rem[DataWidth-2:0], word_i.quo[DataWidth-1]};
    trial = {word_i.rem[DataWidth-1], rsh} - {1'b0, word_i.dvsr};
    if (!trial[DataWidth]) begin
      word_d.rem = trial[DataWidth-1:0];
      word_d.quo = {word_i.quo[DataWidth-2:0], 1'b1};
    end else begin
      word_d.rem = rsh;
      word_d.quo = {word_i.quo[DataWidth-2:0], 1'b0};
    end
    // multiply: consume one B bit, b shifts right each cell
    if (word_i.b[0]) word_d.prod = word_i.prod + word_i.mcand;
    word_d.mcand = {word_i.mcand[DataWidth-2:0], 1'b0};
    word_d.b     = {1'b0, word_i.b[DataWidth-1:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
    end else if (adv_i) begin
      word_q <= word_d;
    end
  end

  assign word_o = word_q;

endmodule

// ----- hdl/alu_32bit_signed_unsigned_top.sv -----
// Top level: 32-bit integer ALU built as a chain of divide/multiply cells.
//
//  channel | valid   | stall   | payload
//  in      | valid_i | stall_o | operation_i, operand_a_i, operand_b_i
//  out     | valid_o | stall_i | result_value_o, remainder_value_o,
//          |         |         | remainder_written_o, divide_by_zero_o
//
// One word enters per cycle while stall_o is low; every word, whatever the
// operation, runs the whole chain: input register, 32 cells, output
// register.
// The cell chain sets the latency; each cell holds one bit step.
// Reset clears all valid flags. A stall on the output freezes the whole
// chain, so stall_o follows stall_i when the output register holds a word.
module alu_32bit_signed_unsigned_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  output logic                            stall_o,
  input  logic [alu32_pkg::OpWidth-1:0]   operation_i,
  input  logic [alu32_pkg::DataWidth-1:0] operand_a_i,
  input  logic [alu32_pkg::DataWidth-1:0] operand_b_i,
  output logic                            valid_o,
  input  logic                            stall_i,
  output logic [alu32_pkg::DataWidth-1:0] result_value_o,
  output logic [alu32_pkg::DataWidth-1:0] remainder_value_o,
  output logic                            remainder_written_o,
  output logic                            divide_by_zero_o
);
  import alu32_pkg::*;

  alu_word_t            chain [NumCells+1];
  alu_word_t            in_d, in_q;
  logic                 adv;
  logic                 an, bn, is_sdiv;
  logic [DataWidth-1:0] abs_a, abs_b;

  logic                 out_vld_q;
  logic [DataWidth-1:0] res_q, rem_q;
  logic                 wr_q, dz_q;
  logic [DataWidth-1:0] res_d, rem_d;
  logic                 wr_d, dz_d;
  alu_word_t            tail;

  // chain moves whenever the output register is free or being taken
  assign adv     = !out_vld_q || !stall_i;
  assign stall_o = !adv;

  assign is_sdiv = (operation_i == OP_DIV);
  assign an      = is_sdiv && operand_a_i[DataWidth-1];
  assign bn      = is_sdiv && operand_b_i[DataWidth-1];
  assign abs_a   = an ? (~operand_a_i + 1'b1) : operand_a_i;
  assign abs_b   = bn ? (~operand_b_i + 1'b1) : operand_b_i;

  always_comb begin
    in_d.vld   = valid_i;
    in_d.op    = operation_i;
    in_d.a     = operand_a_i;
    in_d.b     = operand_b_i;
    in_d.dvsr  = abs_b;
    in_d.quo   = abs_a;
    in_d.rem   = '0;
    in_d.prod  = '0;
    in_d.mcand = operand_a_i;
    in_d.qneg  = an ^ bn;
    in_d.rneg  = an;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_q <= '0;
    end else if (adv) begin
      in_q <= in_d;
    end
  end

  assign chain[0] = in_q;

  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    alu32_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .word_i (chain[g]),
      .word_o (chain[g+1])
    );
  end

  assign tail = chain[NumCells];

  // b was shifted away in the chain, so the add, subtract and logic ops
  // take B from dvsr: for non-sdiv codes dvsr == B.
  always_comb begin
    res_d = tail.a;
    rem_d = '0;
    wr_d  = 1'b0;
    dz_d  = 1'b0;
    case (tail.op)
      OP_ADD, OP_UADD: res_d = tail.a + tail.dvsr;
      OP_SUB, OP_USUB: res_d = tail.a - tail.dvsr;
      OP_MUL, OP_UMUL: res_d = tail.prod;
      OP_AND:          res_d = tail.a & tail.dvsr;
      OP_OR:           res_d = tail.a | tail.dvsr;
      OP_XOR:          res_d = tail.a ^ tail.dvsr;
      OP_NOT:          res_d = ~tail.a;
      OP_DIV, OP_UDIV: begin
        if (tail.dvsr == '0) begin
          dz_d = 1'b1;
        end else begin
          wr_d  = 1'b1;
          res_d = tail.qneg ? (~tail.quo + 1'b1) : tail.quo;
          rem_d = tail.rneg ? (~tail.rem + 1'b1) : tail.rem;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= tail.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
      rem_q <= rem_d;
      wr_q  <= wr_d;
      dz_q  <= dz_d;
    end
  end

  assign valid_o             = out_vld_q;
  assign result_value_o      = res_q;
  assign remainder_value_o   = rem_q;
  assign remainder_written_o = wr_q;
  assign divide_by_zero_o    = dz_q;

`ifndef ASSERT_OFF
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !(remainder_written_o && divide_by_zero_o))
    else $error("remainder written on divide by zero");
  a_rem_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !remainder_written_o) |-> (remainder_value_o == '0))
    else $error("remainder nonzero without division");
  a_stall_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (valid_o && stall_i))
    else $error("input stalled without output backpressure");
`endif

endmodule
